### sv/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared constants, payload structs, status codes and state types.
// ----------------------------------------------------------------------------
package frt_pkg;

   localparam int SLOTS       = 8;
   localparam int SLOT_CNT_W  = $clog2(SLOTS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] MIN_BYTES_RESET = 8'd30;

   typedef enum logic [2:0] {
      ST_EXISTING = 3'd0,
      ST_PLACED   = 3'd1,
      ST_EVICTED  = 3'd2,
      ST_OLDER    = 3'd3,
      ST_RUNT     = 3'd4,
      ST_ZERO     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_APPLY,
      BK_COMPACT
   } back_state_type;

   typedef struct packed {
      logic [15:0] datagram_bytes;
      logic [31:0] seq_number;
      logic [15:0] fragment_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        released;
      logic [31:0] released_seq;
      logic [15:0] released_total;
      logic [31:0] evicted_seq;
      logic [15:0] evicted_remaining;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    runt;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] seq;
      logic [15:0] remaining;
      logic [15:0] total;
   } slot_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } queue_wr_type;

   typedef struct packed {
      logic    full;
      logic    not_empty;
      cmd_type head;
   } queue_rd_type;

endpackage

### sv/frt_front.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker front end
// Holds the minimum length register, accepts headers and tags runts.
// ----------------------------------------------------------------------------
module frt_front import frt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data,
   input  queue_rd_type q_status,
   output queue_wr_type q_write
);

   logic [7:0] min_bytes_ff;
   logic [7:0] min_bytes_in;

   assign csr_ready = 1'b1;
   assign req_ready = !q_status.full;

   always_comb begin
      min_bytes_in = min_bytes_ff;
      if (csr_valid && csr_ready) begin
         min_bytes_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_bytes_ff <= MIN_BYTES_RESET;
      end else begin
         min_bytes_ff <= min_bytes_in;
      end
   end

   always_comb begin
      q_write.push     = req_valid && req_ready;
      q_write.cmd.req  = req_data;
      q_write.cmd.runt = req_data.datagram_bytes < {8'd0, min_bytes_ff};
   end

endmodule

### sv/frt_queue.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker command queue
// Short FIFO that decouples header intake from the table update.
// ----------------------------------------------------------------------------
module frt_queue import frt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type q_write,
   input  logic         q_pop,
   output queue_rd_type q_status
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign do_push = q_write.push && !q_status.full;
   assign do_pop  = q_pop && q_status.not_empty;

   always_comb begin
      q_status.full      = count_ff == QCNT_W'(QUEUE_DEPTH);
      q_status.not_empty = count_ff != '0;
      q_status.head      = entry_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_write.cmd;
      end
   end

endmodule

### sv/frt_back.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker back end
// Owns the slot table: lookup, update, release compaction and the result.
// ----------------------------------------------------------------------------
module frt_back import frt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  queue_rd_type q_status,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   back_state_type   state_ff;
   back_state_type   state_in;

   slot_type         table_ff      [SLOTS];
   slot_type         table_in      [SLOTS];
   slot_type         table_apply   [SLOTS];
   slot_type         table_compact [SLOTS];

   cmd_type          cmd_ff;
   logic [SLOTS-1:0] match_ff;
   logic [SLOTS-1:0] match_in;
   logic [SLOTS-1:0] shift_ff;
   logic [SLOTS-1:0] shift_in;
   logic             any_match_ff;
   logic             any_match_in;
   logic             full_ff;
   logic             full_in;
   logic             older_ff;
   logic             older_in;

   rsp_type          rsp_ff;
   rsp_type          rsp_apply;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             need_compact;

   logic             out_free;
   logic             lookup_en;
   logic             apply_en;
   logic             compact_en;

   logic [SLOT_CNT_W-1:0] pos [SLOTS];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign q_pop     = lookup_en;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_status.not_empty) begin
               state_in = BK_APPLY;
            end
         end
         BK_APPLY: begin
            if (out_free) begin
               state_in = need_compact ? BK_COMPACT : BK_IDLE;
            end
         end
         BK_COMPACT: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      lookup_en  = 1'b0;
      apply_en   = 1'b0;
      compact_en = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            lookup_en = q_status.not_empty;
         end
         BK_APPLY: begin
            apply_en = out_free;
         end
         BK_COMPACT: begin
            compact_en = 1'b1;
         end
         default: begin
            lookup_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      logic found;
      logic seen_free;
      found        = 1'b0;
      seen_free    = 1'b0;
      full_in      = 1'b1;
      match_in     = '0;
      shift_in     = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (table_ff[i].valid && table_ff[i].seq == q_status.head.req.seq_number
             && !found) begin
            match_in[i] = 1'b1;
            found       = 1'b1;
         end
         if (!table_ff[i].valid) begin
            seen_free = 1'b1;
            full_in   = 1'b0;
         end
         shift_in[i] = seen_free;
      end
      if (full_in) begin
         shift_in = '1;
      end
      any_match_in = found;
      older_in     = table_ff[0].seq > q_status.head.req.seq_number;
   end

   always_comb begin
      logic [15:0] rem;
      rem          = '0;
      need_compact = 1'b0;
      rsp_apply    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         table_apply[i] = table_ff[i];
      end
      if (cmd_ff.runt) begin
         rsp_apply.status = ST_RUNT;
      end else if (any_match_ff) begin
         rsp_apply.status = ST_EXISTING;
         for (int i = 0; i < SLOTS; i++) begin
            if (match_ff[i]) begin
               rem = (table_ff[i].remaining != '0) ? table_ff[i].remaining - 16'd1 : '0;
               table_apply[i].remaining = rem;
               if (rem == '0) begin
                  table_apply[i].valid     = 1'b0;
                  need_compact             = 1'b1;
                  rsp_apply.released       = 1'b1;
                  rsp_apply.released_seq   = table_ff[i].seq;
                  rsp_apply.released_total = table_ff[i].total;
               end
            end
         end
      end else if (cmd_ff.req.fragment_count == '0) begin
         rsp_apply.status = ST_ZERO;
      end else if (full_ff && older_ff) begin
         rsp_apply.status = ST_OLDER;
      end else begin
         if (full_ff) begin
            rsp_apply.status            = ST_EVICTED;
            rsp_apply.evicted_seq       = table_ff[0].seq;
            rsp_apply.evicted_remaining = table_ff[0].remaining;
         end else begin
            rsp_apply.status = ST_PLACED;
         end
         for (int i = 0; i < SLOTS - 1; i++) begin
            if (shift_ff[i]) begin
               table_apply[i] = table_ff[i + 1];
            end
         end
         table_apply[SLOTS-1].valid     = 1'b1;
         table_apply[SLOTS-1].seq       = cmd_ff.req.seq_number;
         table_apply[SLOTS-1].remaining = cmd_ff.req.fragment_count - 16'd1;
         table_apply[SLOTS-1].total     = cmd_ff.req.fragment_count;
         if (cmd_ff.req.fragment_count == 16'd1) begin
            table_apply[SLOTS-1].valid = 1'b0;
            need_compact               = 1'b1;
            rsp_apply.released         = 1'b1;
            rsp_apply.released_seq     = cmd_ff.req.seq_number;
            rsp_apply.released_total   = cmd_ff.req.fragment_count;
         end
      end
   end

   always_comb begin
      pos[0] = '0;
      for (int r = 1; r < SLOTS; r++) begin
         pos[r] = pos[r-1] + SLOT_CNT_W'(table_ff[r-1].valid);
      end
      for (int w = 0; w < SLOTS; w++) begin
         table_compact[w]       = table_ff[w];
         table_compact[w].valid = 1'b0;
         for (int r = 0; r < SLOTS; r++) begin
            if (table_ff[r].valid && pos[r] == SLOT_CNT_W'(w)) begin
               table_compact[w] = table_ff[r];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         if (apply_en) begin
            table_in[i] = table_apply[i];
         end else if (compact_en) begin
            table_in[i] = table_compact[i];
         end else begin
            table_in[i] = table_ff[i];
         end
      end
      if (apply_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            table_ff[i].valid <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < SLOTS; i++) begin
            table_ff[i] <= table_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_en) begin
         cmd_ff       <= q_status.head;
         match_ff     <= match_in;
         shift_ff     <= shift_in;
         any_match_ff <= any_match_in;
         full_ff      <= full_in;
         older_ff     <= older_in;
      end
      if (apply_en) begin
         rsp_ff <= rsp_apply;
      end
   end

endmodule

### sv/fragment_reassembly_tracker_top.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Tracks partial frames in a fixed slot table from received fragment headers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid / req_ready  req_data (bytes, sequence, count)
//  rsp      out        rsp_valid / rsp_ready  rsp_data (status, release, eviction)
//  csr      in         csr_valid / csr_ready  csr_data (minimum datagram length)
//
// The table sequencer handles each header in a lookup step and then an update
// step, which waits while a result is still untaken; a transaction that releases
// a frame adds a step that compacts the table. A two-entry queue lets headers
// arrive while the table is busy or a result waits. Reset is synchronous and frees every slot at once.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_top import frt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   queue_wr_type q_write;
   queue_rd_type q_status;
   logic         q_pop;

   frt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .q_write   (q_write)
   );

   frt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_write  (q_write),
      .q_pop    (q_pop),
      .q_status (q_status)
   );

   frt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_release_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.released |->
         rsp_data.released_seq == '0 && rsp_data.released_total == '0)
      else $error("Release fields are set without a release.");

   a_evict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_EVICTED |->
         rsp_data.evicted_seq == '0 && rsp_data.evicted_remaining == '0)
      else $error("Eviction fields are set without an eviction.");

   a_release_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.released |->
         rsp_data.status == ST_EXISTING || rsp_data.status == ST_PLACED ||
         rsp_data.status == ST_EVICTED)
      else $error("A frame was released by a rejected transaction.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.not_empty)
      else $error("The table sequencer popped an empty queue.");

endmodule

### bench/reassembly_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fragment reassembly checker
// Watches the header, result and register channels of the tracker. It keeps
// its own copy of the slot table and of the minimum datagram length, predicts
// the result of every accepted header, and compares each result transaction
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module reassembly_checker import frt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         mismatch_count,
   output int         outstanding,
   output int         checked_count,
   output int         release_count
);

   localparam int NO_SLOT = -1;

   logic [7:0] min_bytes;
   slot_type   frames[SLOTS];
   rsp_type    expected_results[$];
   rsp_type    want;
   int         errors;
   int         checked;
   int         releases;

   function automatic rsp_type advance_table(input req_type hdr);
      rsp_type res;
      int      match_idx;
      int      free_idx;
      int      hit;
      int      w;
      res = '0;
      match_idx = NO_SLOT;
      free_idx = NO_SLOT;
      hit = NO_SLOT;
      if (hdr.datagram_bytes < {8'd0, min_bytes}) begin
         res.status = ST_RUNT;
         return res;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (frames[i].valid) begin
            if (frames[i].seq == hdr.seq_number && match_idx == NO_SLOT) begin
               match_idx = i;
            end
         end else if (free_idx == NO_SLOT) begin
            free_idx = i;
         end
      end
      if (match_idx != NO_SLOT) begin
         res.status = ST_EXISTING;
         if (frames[match_idx].remaining != 16'd0) begin
            frames[match_idx].remaining = frames[match_idx].remaining - 16'd1;
         end
         hit = match_idx;
      end else if (hdr.fragment_count == 16'd0) begin
         res.status = ST_ZERO;
      end else if (free_idx == NO_SLOT && frames[0].seq > hdr.seq_number) begin
         res.status = ST_OLDER;
      end else begin
         if (free_idx == NO_SLOT) begin
            res.status = ST_EVICTED;
            res.evicted_seq = frames[0].seq;
            res.evicted_remaining = frames[0].remaining;
            free_idx = 0;
         end else begin
            res.status = ST_PLACED;
         end
         for (int i = free_idx; i < SLOTS - 1; i++) begin
            frames[i] = frames[i + 1];
         end
         frames[SLOTS - 1].valid = 1'b1;
         frames[SLOTS - 1].seq = hdr.seq_number;
         frames[SLOTS - 1].remaining = hdr.fragment_count - 16'd1;
         frames[SLOTS - 1].total = hdr.fragment_count;
         hit = SLOTS - 1;
      end
      if (hit != NO_SLOT && frames[hit].valid && frames[hit].remaining == 16'd0) begin
         res.released = 1'b1;
         res.released_seq = frames[hit].seq;
         res.released_total = frames[hit].total;
         frames[hit].valid = 1'b0;
         w = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (frames[i].valid) begin
               frames[w] = frames[i];
               w++;
            end
         end
         for (int i = w; i < SLOTS; i++) begin
            frames[i] = '0;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         min_bytes = MIN_BYTES_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            frames[i] = '0;
         end
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            min_bytes = csr_data;
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(advance_table(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected result %0d: status %0d released %0b seq %h",
                           checked, rsp_data.status, rsp_data.released,
                           rsp_data.released_seq);
               end
            end else begin
               want = expected_results.pop_front();
               if (want.released) begin
                  releases++;
               end
               if (rsp_data !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch on result %0d: expected status %0d released %0b",
                              checked, want.status, want.released);
                     $display("   expected seq %h total %0d evicted %h remaining %0d",
                              want.released_seq, want.released_total,
                              want.evicted_seq, want.evicted_remaining);
                     $display("   got status %0d released %0b seq %h total %0d",
                              rsp_data.status, rsp_data.released,
                              rsp_data.released_seq, rsp_data.released_total);
                     $display("   got evicted %h remaining %0d",
                              rsp_data.evicted_seq, rsp_data.evicted_remaining);
                  end
               end
            end
         end
      end
      mismatch_count <= errors;
      outstanding <= expected_results.size();
      checked_count <= checked;
      release_count <= releases;
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Drives fragment headers and minimum-length writes into the tracker with
// random gaps on the header and result channels. A directed opening covers runts, zero counts,
// single fragment frames, a full table with eviction and rejection of older
// frames; random phases then run realistic frame traffic at several settings.
// ----------------------------------------------------------------------------
module tb_top import frt_pkg::*;;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;
   int          mismatch_count;
   int          outstanding;
   int          checked_count;
   int          release_count;
   bit          steady;
   int          sent;
   logic [7:0]  min_bytes_now;
   logic [31:0] next_seq;
   logic [31:0] live_seqs[$];

   fragment_reassembly_tracker_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   reassembly_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .release_count  (release_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic send_header(input logic [15:0] nbytes, input logic [31:0] seq,
                              input logic [15:0] count);
      req_type hdr;
      int      gap;
      hdr.datagram_bytes = nbytes;
      hdr.seq_number = seq;
      hdr.fragment_count = count;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= hdr;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_min_bytes(input logic [7:0] value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      min_bytes_now = value;
   endtask

   task automatic send_random_header();
      int          pick;
      logic [15:0] nbytes;
      logic [15:0] count;
      logic [31:0] seq;
      pick = $urandom_range(0, 99);
      nbytes = 16'($urandom_range(min_bytes_now, 65535));
      count = 16'($urandom_range(1, 5));
      seq = next_seq;
      if (pick < 45 && live_seqs.size() > 0) begin
         seq = live_seqs[$urandom_range(0, live_seqs.size() - 1)];
         if ($urandom_range(0, 9) == 0) begin
            count = 16'd0;
         end
      end else if (pick < 72) begin
         next_seq = next_seq + $urandom_range(1, 3);
         seq = next_seq;
         if ($urandom_range(0, 9) == 0) begin
            count = 16'($urandom_range(6, 65535));
         end
         live_seqs.push_back(seq);
         if (live_seqs.size() > 12) begin
            live_seqs.delete(0);
         end
      end else if (pick < 80) begin
         seq = next_seq - $urandom_range(16, 400);
      end else if (pick < 86) begin
         nbytes = (min_bytes_now == 8'd0) ? 16'd0 :
                  16'($urandom_range(0, min_bytes_now - 1));
      end else if (pick < 91) begin
         count = 16'd0;
         seq = next_seq + $urandom_range(1000, 5000);
      end else begin
         nbytes = 16'($urandom);
         seq = $urandom;
         count = 16'($urandom);
      end
      if ($urandom_range(0, 19) == 0) begin
         nbytes = {8'd0, min_bytes_now};
      end
      send_header(nbytes, seq, count);
   endtask

   task automatic run_random(input int n);
      next_seq = $urandom;
      live_seqs.delete();
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         if (i % 90 == 89) begin
            wait_for_results();
         end
         send_random_header();
      end
   endtask

   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         gap = steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      steady = 1'b0;
      sent = 0;
      min_bytes_now = MIN_BYTES_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Runts at zero and just below the reset minimum, then a zero count at the boundary.
      send_header(16'd0, 32'd1, 16'd1);
      send_header(16'd29, 32'd1, 16'd1);
      send_header(16'd30, 32'd1, 16'd0);
      // A single fragment frame is placed and released at once.
      send_header(16'hFFFF, 32'hFFFF_FFFF, 16'd1);
      send_header(16'd64, 32'd10, 16'd3);
      send_header(16'd64, 32'd10, 16'd3);
      send_header(16'd64, 32'd11, 16'd2);
      send_header(16'd64, 32'd10, 16'd3);
      // Fill the table with frames that never finish.
      for (int i = 0; i < 7; i++) begin
         send_header(16'd1500, 32'd100 + i, 16'hFFFF);
      end
      send_header(16'd1500, 32'd107, 16'hFFFF);
      send_header(16'd1500, 32'd200, 16'd2);
      send_header(16'd1500, 32'd50, 16'd1);
      send_header(16'd1500, 32'd101, 16'd0);
      send_header(16'd1500, 32'd300, 16'd1);
      send_header(16'd1500, 32'd0, 16'h8000);

      set_min_bytes(8'd0);
      run_random(220);
      set_min_bytes(8'd255);
      run_random(120);
      set_min_bytes(8'($urandom_range(1, 254)));
      run_random(200);
      set_min_bytes(8'd30);
      run_random(200);

      wait_for_results();
      repeat (16) @(posedge clock);
      $display("Covered %0d fragment headers over five minimum-length settings,",
               sent);
      $display("0 and 255 included; compared %0d results, saw %0d releases, %0d mismatches.",
               checked_count, release_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

### files.f
sv/frt_pkg.sv
sv/frt_front.sv
sv/frt_queue.sv
sv/frt_back.sv
sv/fragment_reassembly_tracker_top.sv
bench/reassembly_checker.sv
bench/tb_top.sv
